// File: hw/rtl/lfdt_pkg.sv
package lfdt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int FIRST_DESC  = 2;
    localparam int DESC_W      = 7;
    localparam int HANDLE_W    = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OFF_W       = ((DESC_W > IDX_W) ? DESC_W : IDX_W) + 2;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_REMOVE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef struct packed {
        func_t                func;
        logic [DESC_W-1:0]    desc_in;
        logic [HANDLE_W-1:0]  handle_in;
    } req_t;

    typedef struct packed {
        logic [DESC_W-1:0]    desc_out;
        logic [HANDLE_W-1:0]  handle_out;
        logic                 found;
        logic                 full_res;
        logic                 last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_RD,
        ST_RESP,
        ST_CLR_SCAN,
        ST_CLR_DATA,
        ST_CLR_END
    } state_t;

endpackage

// File: hw/rtl/lowest_free_descriptor_table_unit.sv
// Descriptor table of TABLE_DEPTH slots; slot i holds descriptor FIRST_DESC + i. A small
// sequencer steps one slot compare per cycle and owns a single-port handle memory with a
// registered read. The block takes one request at a time and stalls its input until that
// request is finished; the next transfer is taken only once the sequencer is back in ST_IDLE,
// after the result is registered. An insert scans upward from slot 0 and stops at the first
// free slot, or reports full once the last slot is found held. Lookup and remove read the
// memory in ST_RD and answer from the registered read data in ST_RESP. A clear walks every
// slot, one per cycle, with an added ST_CLR_DATA step on each held slot that frees it;
// its results leave through a one-deep look-ahead so that the final one carries last. A
// stalled output register holds the sequencer wherever it has a result to hand over.
module lowest_free_descriptor_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lfdt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lfdt_pkg::rsp_t rsp
);
    import lfdt_pkg::*;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    func_t                  func_reg;
    logic [DESC_W-1:0]      desc_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    rsp_t                   pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;
    logic [HANDLE_W-1:0]    rdata_reg;
    logic [HANDLE_W-1:0]    handle_mem [TABLE_DEPTH];

    logic                   load;
    logic                   emit;
    rsp_t                   emit_rsp;
    logic                   mem_we;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic                   out_free;
    logic                   idx_last;
    logic [OFF_W-1:0]       desc_off;
    logic                   in_range;
    logic [IDX_W-1:0]       slot_idx;
    logic                   hit;
    logic [DESC_W-1:0]      idx_desc;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign idx_last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign desc_off = OFF_W'(desc_reg) - OFF_W'(FIRST_DESC);
    assign in_range = (OFF_W'(desc_reg) >= OFF_W'(FIRST_DESC))
                      && (desc_off < OFF_W'(TABLE_DEPTH));
    assign slot_idx = desc_off[IDX_W-1:0];
    assign hit      = in_range && used_reg[slot_idx];
    assign idx_desc = DESC_W'(OFF_W'(idx_reg) + OFF_W'(FIRST_DESC));

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.func) inside
                        FN_INSERT:            state_next = ST_INS_SCAN;
                        FN_LOOKUP, FN_REMOVE: state_next = ST_RD;
                        FN_CLEAR:             state_next = ST_CLR_SCAN;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_SCAN:
            begin
                if ((!used_reg[idx_reg] || idx_last) && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_SCAN:
            begin
                if (used_reg[idx_reg])
                begin
                    state_next = ST_CLR_DATA;
                end
                else if (idx_last)
                begin
                    state_next = ST_CLR_END;
                end
            end
            ST_CLR_DATA:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = idx_last ? ST_CLR_END : ST_CLR_SCAN;
                end
            end
            ST_CLR_END:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and results.
    always_comb
    begin
        load            = 1'b0;
        emit            = 1'b0;
        emit_rsp        = '0;
        used_next       = used_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = slot_idx;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    load            = 1'b1;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_INS_SCAN:
            begin
                if (!used_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        emit               = 1'b1;
                        emit_rsp.desc_out  = idx_desc;
                        emit_rsp.handle_out = handle_reg;
                        emit_rsp.found     = 1'b1;
                        emit_rsp.last      = 1'b1;
                        mem_we             = 1'b1;
                        used_next[idx_reg] = 1'b1;
                    end
                end
                else if (idx_last)
                begin
                    if (out_free)
                    begin
                        emit              = 1'b1;
                        emit_rsp.full_res = 1'b1;
                        emit_rsp.last     = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RD:
            begin
                mem_re = 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    emit_rsp.desc_out   = desc_reg;
                    emit_rsp.handle_out = hit ? rdata_reg : '0;
                    emit_rsp.found      = hit;
                    emit_rsp.last       = 1'b1;
                    if (func_reg == FN_REMOVE && hit)
                    begin
                        used_next[slot_idx] = 1'b0;
                    end
                end
            end
            ST_CLR_SCAN:
            begin
                if (used_reg[idx_reg])
                begin
                    mem_re             = 1'b1;
                    mem_raddr          = idx_reg;
                    used_next[idx_reg] = 1'b0;
                end
                else if (!idx_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CLR_DATA:
            begin
                // The held result goes out only once a later one proves it is not the last.
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        emit     = 1'b1;
                        emit_rsp = pend_reg;
                    end
                    pend_next.desc_out   = idx_desc;
                    pend_next.handle_out = rdata_reg;
                    pend_next.found      = 1'b1;
                    pend_next.full_res   = 1'b0;
                    pend_next.last       = 1'b0;
                    pend_valid_next      = 1'b1;
                    if (!idx_last)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_CLR_END:
            begin
                if (pend_valid_reg && out_free)
                begin
                    emit            = 1'b1;
                    emit_rsp        = pend_reg;
                    emit_rsp.last   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        if (load)
        begin
            func_reg   <= req.func;
            desc_reg   <= req.desc_in;
            handle_reg <= req.handle_in;
        end
        if (emit)
        begin
            rsp_reg <= emit_rsp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            handle_mem[idx_reg] <= handle_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= handle_mem[mem_raddr];
        end
    end

endmodule

// File: bench/desc_table_check_pkg.sv
package desc_table_check_pkg;
    import lfdt_pkg::*;

    // Shadow copy of the descriptor table plus the queue of results still owed by the block.
    class desc_table_sb;
        bit                  held [TABLE_DEPTH];
        logic [HANDLE_W-1:0] stored [TABLE_DEPTH];
        rsp_t                awaited [$];
        int                  errors;
        int                  n_req;
        int                  n_rsp;
        int                  n_full;
        int                  n_miss;
        int                  n_cleared;

        function new();
            foreach (held[i])
            begin
                held[i]   = 1'b0;
                stored[i] = '0;
            end
            errors    = 0;
            n_req     = 0;
            n_rsp     = 0;
            n_full    = 0;
            n_miss    = 0;
            n_cleared = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at result %0d: %s", n_rsp, msg);
            errors++;
        endtask

        // A descriptor currently held, or any in-range one when the table is empty.
        function logic [DESC_W-1:0] held_desc();
            int pool [$];
            foreach (held[i])
                if (held[i])
                    pool.push_back(i);
            if (pool.size() == 0)
                return DESC_W'($urandom_range(FIRST_DESC, FIRST_DESC + TABLE_DEPTH - 1));
            return DESC_W'(FIRST_DESC + pool[$urandom_range(0, pool.size() - 1)]);
        endfunction

        function void note_request(input req_t r);
            rsp_t e;
            int   slot;
            int   remaining;
            e      = '0;
            e.last = 1'b1;
            n_req++;
            case (r.func) inside
                FN_INSERT:
                begin
                    slot = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (!held[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                    begin
                        e.full_res = 1'b1;
                        n_full++;
                    end
                    else
                    begin
                        held[slot]   = 1'b1;
                        stored[slot] = r.handle_in;
                        e.desc_out   = DESC_W'(FIRST_DESC + slot);
                        e.handle_out = r.handle_in;
                        e.found      = 1'b1;
                    end
                    awaited.push_back(e);
                end
                FN_LOOKUP, FN_REMOVE:
                begin
                    slot       = int'(r.desc_in) - FIRST_DESC;
                    e.desc_out = r.desc_in;
                    if (slot >= 0 && slot < TABLE_DEPTH && held[slot])
                    begin
                        e.handle_out = stored[slot];
                        e.found      = 1'b1;
                        if (r.func == FN_REMOVE)
                            held[slot] = 1'b0;
                    end
                    else
                        n_miss++;
                    awaited.push_back(e);
                end
                FN_CLEAR:
                begin
                    remaining = 0;
                    foreach (held[i])
                        if (held[i])
                            remaining++;
                    // Freed entries come out in ascending order; an empty table owes nothing.
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (held[i])
                        begin
                            remaining--;
                            e.desc_out   = DESC_W'(FIRST_DESC + i);
                            e.handle_out = stored[i];
                            e.found      = 1'b1;
                            e.last       = (remaining == 0);
                            held[i]      = 1'b0;
                            awaited.push_back(e);
                            n_cleared++;
                        end
                    end
                end
            endcase
        endfunction

        task check_response(input rsp_t got);
            rsp_t want;
            n_rsp++;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result desc %0d handle %h", got.desc_out,
                                 got.handle_out));
                return;
            end
            want = awaited.pop_front();
            if (got.desc_out !== want.desc_out)
                report($sformatf("desc_out %0d, expected %0d", got.desc_out, want.desc_out));
            if (got.handle_out !== want.handle_out)
                report($sformatf("handle_out %h, expected %h", got.handle_out,
                                 want.handle_out));
            if (got.found !== want.found)
                report($sformatf("found %b, expected %b", got.found, want.found));
            if (got.full_res !== want.full_res)
                report($sformatf("full_res %b, expected %b", got.full_res, want.full_res));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

endpackage

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfdt_pkg::*;
    import desc_table_check_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    bit   rsp_idling = 1'b1;
    int   stall_run  = 0;

    desc_table_sb sb;

    lowest_free_descriptor_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len(input int low);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(low, 3);
        else if (roll < 93)
            return $urandom_range(4, 9);
        return $urandom_range(12, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_run > 0)
            stall_run <= stall_run - 1;
        else if (rsp_idling && $urandom_range(0, 99) < 35)
        begin
            rsp_stall <= 1'b1;
            stall_run <= gap_len(0);
        end
        else
        begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 6);
        end
    end

    // Results are checked before the request of the same edge is noted; the block holds
    // one request at a time, so a result here always belongs to an earlier transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (req_valid && !req_stall)
                sb.note_request(req);
        end
    end

    task automatic send_req(input req_t r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 1) == 0) ? 0 : gap_len(1);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // The extra edge lets the monitor note the last transfer before the queue is looked at.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic put(input func_t f, input int d, input int h);
        req_t r;
        r.func      = f;
        r.desc_in   = DESC_W'(d);
        r.handle_in = HANDLE_W'(h);
        send_req(r);
        sender_gap();
    endtask

    task automatic fill_table();
        put(FN_CLEAR, $urandom, $urandom);
        for (int k = 0; k < TABLE_DEPTH + 6; k++)
            put(FN_INSERT, $urandom, $urandom);
    endtask

    task automatic run_phase(input int count, input int ins_w, input bit calm);
        req_t r;
        int   roll;
        rsp_idling <= !calm;
        for (int k = 0; k < count; k++)
        begin
            r.handle_in = HANDLE_W'($urandom);
            r.desc_in   = DESC_W'($urandom);
            roll        = $urandom_range(0, 99);
            if (roll < 3)
                r.func = FN_CLEAR;
            else if (roll < 3 + ins_w)
                r.func = FN_INSERT;
            else if (roll % 2 == 0)
                r.func = FN_LOOKUP;
            else
                r.func = FN_REMOVE;
            if ((r.func == FN_LOOKUP || r.func == FN_REMOVE) && $urandom_range(0, 99) < 60)
                r.desc_in = sb.held_desc();
            send_req(r);
            if (!calm)
                sender_gap();
            if ($urandom_range(0, 99) < 3)
                drain();
        end
        rsp_idling <= 1'b1;
    endtask

    initial
    begin
        int ins_w;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Clear of an empty table owes no result at all.
        put(FN_CLEAR, 5, 16'h1234);
        put(FN_LOOKUP, 0, 16'hFFFF);
        put(FN_LOOKUP, 1, 0);
        put(FN_LOOKUP, FIRST_DESC, 0);
        put(FN_LOOKUP, FIRST_DESC + TABLE_DEPTH, 0);
        put(FN_LOOKUP, 127, 0);
        put(FN_INSERT, 127, 16'h0000);
        put(FN_INSERT, 0, 16'hFFFF);
        put(FN_INSERT, 42, 16'hA5A5);
        put(FN_LOOKUP, 2, 0);
        put(FN_LOOKUP, 3, 0);
        put(FN_LOOKUP, 4, 16'h5A5A);
        put(FN_REMOVE, 3, 0);
        put(FN_LOOKUP, 3, 0);
        put(FN_REMOVE, 0, 0);
        put(FN_REMOVE, 127, 0);
        put(FN_REMOVE, FIRST_DESC + TABLE_DEPTH, 0);
        // The freed descriptor is the lowest again and must be handed out once more.
        put(FN_INSERT, 0, 16'h1234);
        put(FN_CLEAR, 0, 0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: ins_w = 55;
                1: ins_w = 85;
                2: ins_w = 40;
                3: ins_w = 95;
                4: ins_w = 30;
                default: ins_w = 65;
            endcase
            run_phase(45, ins_w, p == 2);
            drain();
            if (p == 1)
            begin
                fill_table();
                drain();
            end
        end

        drain();
        repeat (3 * TABLE_DEPTH) @(posedge clk);
        $display("Covered %0d requests and %0d results: directed edge cases, a full fill,",
                 sb.n_req, sb.n_rsp);
        $display("then random mixes; %0d full inserts, %0d misses, %0d entries cleared.",
                 sb.n_full, sb.n_miss, sb.n_cleared);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("timeout with %0d results outstanding", sb.awaited.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
